// File: rtl/rpct_pkg.sv
// ----------------------------------------------------------------------------
// rpct_pkg
// Shared types, operation and status codes for the power calibration table.
// ----------------------------------------------------------------------------
package rpct_pkg;

    localparam int CHANNELS_DEF     = 16;
    localparam int ENTRIES_DEF      = 8;
    localparam int SETTING_BITS_DEF = 64;

    localparam int SET_PORT_W = 64;
    localparam int POWER_W    = 16;
    localparam int CHAN_W     = 8;

    localparam logic [CHAN_W-1:0]         FIRST_CHANNEL = 8'd11;
    localparam logic signed [POWER_W-1:0] TARGET_UNSET  = 16'sd32767;

    typedef logic [1:0] op_t;
    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_CLEAR  = 2'd1;
    localparam op_t OP_SET    = 2'd2;
    localparam op_t OP_LOOKUP = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_INVALID   = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic load;
        logic walk;
        logic commit;
        logic lookup;
    } rpct_ctl_t;

endpackage

// File: rtl/rpct_cell.sv
// ----------------------------------------------------------------------------
// rpct_cell
// One sorted slot position for every channel: reads its slot, joins the
// match walk toward the upper neighbor, and takes part in the sorted insert.
// ----------------------------------------------------------------------------
module rpct_cell #(
    parameter int CHANNELS     = rpct_pkg::CHANNELS_DEF,
    parameter int SETTING_BITS = rpct_pkg::SETTING_BITS_DEF,
    parameter int IDX          = 0,
    parameter int CNT_W        = 4,
    parameter int CH_W         = 4
) (
    input  logic                                aclk,
    input  rpct_pkg::rpct_ctl_t                 ctl,
    input  logic [CH_W-1:0]                     ch_idx,
    input  logic [CNT_W-1:0]                    count,
    input  logic signed [rpct_pkg::POWER_W-1:0] key,
    input  logic [SETTING_BITS-1:0]             new_setting,
    input  logic                                prev_lt,
    input  logic signed [rpct_pkg::POWER_W-1:0] prev_power,
    input  logic [SETTING_BITS-1:0]             prev_setting,
    input  logic                                prev_found,
    input  logic [SETTING_BITS-1:0]             prev_found_setting,
    output logic                                lt,
    output logic signed [rpct_pkg::POWER_W-1:0] rd_power,
    output logic [SETTING_BITS-1:0]             rd_setting,
    output logic                                found,
    output logic [SETTING_BITS-1:0]             found_setting
);

    logic signed [rpct_pkg::POWER_W-1:0] slot_power_reg [CHANNELS];
    logic [SETTING_BITS-1:0]             slot_setting_reg [CHANNELS];

    logic signed [rpct_pkg::POWER_W-1:0] rd_power_reg;
    logic [SETTING_BITS-1:0]             rd_setting_reg;
    logic                                found_reg;
    logic [SETTING_BITS-1:0]             found_setting_reg;

    logic                                slot_valid;
    logic                                hit;
    logic                                wr_en;
    logic signed [rpct_pkg::POWER_W-1:0] wr_power_next;
    logic [SETTING_BITS-1:0]             wr_setting_next;

    assign slot_valid = CNT_W'(IDX) < count;
    assign lt         = slot_valid && (rd_power_reg < key);
    assign hit        = slot_valid && (ctl.lookup ? (rd_power_reg <= key)
                                                  : (rd_power_reg == key));

    assign wr_en           = ctl.commit && (CNT_W'(IDX) <= count) && !lt;
    assign wr_power_next   = prev_lt ? key : prev_power;
    assign wr_setting_next = prev_lt ? new_setting : prev_setting;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_power_reg[ch_idx]   <= wr_power_next;
            slot_setting_reg[ch_idx] <= wr_setting_next;
        end
        if (ctl.load) begin
            rd_power_reg      <= slot_power_reg[ch_idx];
            rd_setting_reg    <= slot_setting_reg[ch_idx];
            found_reg         <= 1'b0;
            found_setting_reg <= '0;
        end else if (ctl.walk) begin
            found_reg         <= hit || prev_found;
            found_setting_reg <= hit ? rd_setting_reg : prev_found_setting;
        end
    end

    assign rd_power      = rd_power_reg;
    assign rd_setting    = rd_setting_reg;
    assign found         = found_reg;
    assign found_setting = found_setting_reg;

endmodule

// File: rtl/radio_power_calibration_table.sv
// ----------------------------------------------------------------------------
// radio_power_calibration_table
// Per-channel sorted calibration table with add, clear, set target and lookup.
// ----------------------------------------------------------------------------
// A new transaction is taken only in S_IDLE, after the previous one has passed
// through S_READ, the registered match walk through the row of ENTRIES slot
// cells, S_FIN and S_OUT; hold a finished result while the previous one is
// still waiting on m_ready.
// Reset clears all entry counts and sets every target power to unset (32767);
// slot contents are undefined until written.
// ----------------------------------------------------------------------------
module radio_power_calibration_table #(
    parameter int CHANNELS     = rpct_pkg::CHANNELS_DEF,
    parameter int ENTRIES      = rpct_pkg::ENTRIES_DEF,
    parameter int SETTING_BITS = rpct_pkg::SETTING_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_op,
    input  logic [rpct_pkg::CHAN_W-1:0]            s_channel,
    input  logic signed [rpct_pkg::POWER_W-1:0]    s_power,
    input  logic [rpct_pkg::SET_PORT_W-1:0]        s_setting_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [1:0]                             m_status,
    output logic [rpct_pkg::SET_PORT_W-1:0]        m_setting_out
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                          state_reg, state_next;
    logic [CNT_W-1:0]                    walk_cnt_reg, walk_cnt_next;
    rpct_pkg::op_t                       op_reg;
    logic                                chan_ok_reg;
    logic [CH_W-1:0]                     ch_idx_reg;
    logic signed [rpct_pkg::POWER_W-1:0] power_reg;
    logic [SETTING_BITS-1:0]             setting_reg;

    logic signed [rpct_pkg::POWER_W-1:0] target_reg [CHANNELS];
    logic [CNT_W-1:0]                    count_reg [CHANNELS];

    rpct_pkg::status_t                   res_status_reg, res_status_next;
    logic [SETTING_BITS-1:0]             res_setting_reg, res_setting_next;
    logic                                m_valid_reg, m_valid_next;
    rpct_pkg::status_t                   m_status_reg;
    logic [SETTING_BITS-1:0]             m_setting_reg;

    logic [rpct_pkg::CHAN_W-1:0]         chan_off;
    logic                                chan_ok;
    logic                                accept;
    logic                                out_load;
    logic                                cnt_inc;
    logic                                clear_all;
    logic                                tgt_wr;
    logic [CNT_W-1:0]                    cnt_cur;
    logic signed [rpct_pkg::POWER_W-1:0] tgt_cur;
    logic signed [rpct_pkg::POWER_W-1:0] key;
    rpct_pkg::rpct_ctl_t                 ctl;

    logic                                lt_w       [ENTRIES];
    logic signed [rpct_pkg::POWER_W-1:0] pw_w       [ENTRIES];
    logic [SETTING_BITS-1:0]             st_w       [ENTRIES];
    logic                                fd_w       [ENTRIES];
    logic [SETTING_BITS-1:0]             fs_w       [ENTRIES];

    assign chan_off = s_channel - rpct_pkg::FIRST_CHANNEL;
    assign chan_ok  = (s_channel >= rpct_pkg::FIRST_CHANNEL) && (int'(chan_off) < CHANNELS);
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign cnt_cur  = count_reg[ch_idx_reg];
    assign tgt_cur  = target_reg[ch_idx_reg];
    assign key      = (op_reg == rpct_pkg::OP_LOOKUP) ? tgt_cur : power_reg;

    always_comb begin
        state_next       = state_reg;
        walk_cnt_next    = walk_cnt_reg;
        res_status_next  = res_status_reg;
        res_setting_next = res_setting_reg;
        ctl              = '0;
        ctl.lookup       = (op_reg == rpct_pkg::OP_LOOKUP);
        cnt_inc          = 1'b0;
        clear_all        = 1'b0;
        tgt_wr           = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                ctl.load      = 1'b1;
                walk_cnt_next = '0;
                state_next    = S_WALK;
            end
            S_WALK: begin
                ctl.walk      = 1'b1;
                walk_cnt_next = walk_cnt_reg + 1'b1;
                if (walk_cnt_reg == CNT_W'(ENTRIES - 1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                res_setting_next = '0;
                res_status_next  = rpct_pkg::ST_OK;
                if (!chan_ok_reg && op_reg != rpct_pkg::OP_CLEAR) begin
                    res_status_next = rpct_pkg::ST_INVALID;
                end else begin
                    case (op_reg)
                        rpct_pkg::OP_ADD: begin
                            if (cnt_cur >= CNT_W'(ENTRIES)) begin
                                res_status_next = rpct_pkg::ST_FULL;
                            end else if (fd_w[ENTRIES-1]) begin
                                res_status_next = rpct_pkg::ST_INVALID;
                            end else begin
                                ctl.commit = 1'b1;
                                cnt_inc    = 1'b1;
                            end
                        end
                        rpct_pkg::OP_CLEAR: begin
                            clear_all = 1'b1;
                        end
                        rpct_pkg::OP_SET: begin
                            tgt_wr = 1'b1;
                        end
                        default: begin
                            if (tgt_cur == rpct_pkg::TARGET_UNSET || !fd_w[ENTRIES-1]) begin
                                res_status_next = rpct_pkg::ST_NOT_FOUND;
                            end else begin
                                res_setting_next = fs_w[ENTRIES-1];
                            end
                        end
                    endcase
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                target_reg[c] <= rpct_pkg::TARGET_UNSET;
                count_reg[c]  <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (clear_all) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    count_reg[c] <= '0;
                end
            end else if (cnt_inc) begin
                count_reg[ch_idx_reg] <= cnt_cur + 1'b1;
            end
            if (tgt_wr) begin
                target_reg[ch_idx_reg] <= power_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        walk_cnt_reg    <= walk_cnt_next;
        res_status_reg  <= res_status_next;
        res_setting_reg <= res_setting_next;
        if (accept) begin
            op_reg      <= s_op;
            chan_ok_reg <= chan_ok;
            ch_idx_reg  <= chan_off[CH_W-1:0];
            power_reg   <= s_power;
            setting_reg <= s_setting_in[SETTING_BITS-1:0];
        end
        if (out_load) begin
            m_status_reg  <= res_status_reg;
            m_setting_reg <= res_setting_reg;
        end
    end

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic                                prev_lt;
        logic signed [rpct_pkg::POWER_W-1:0] prev_power;
        logic [SETTING_BITS-1:0]             prev_setting;
        logic                                prev_found;
        logic [SETTING_BITS-1:0]             prev_found_setting;

        if (i == 0) begin : g_head
            assign prev_lt            = 1'b1;
            assign prev_power         = '0;
            assign prev_setting       = '0;
            assign prev_found         = 1'b0;
            assign prev_found_setting = '0;
        end else begin : g_link
            assign prev_lt            = lt_w[i-1];
            assign prev_power         = pw_w[i-1];
            assign prev_setting       = st_w[i-1];
            assign prev_found         = fd_w[i-1];
            assign prev_found_setting = fs_w[i-1];
        end

        rpct_cell #(
            .CHANNELS     (CHANNELS),
            .SETTING_BITS (SETTING_BITS),
            .IDX          (i),
            .CNT_W        (CNT_W),
            .CH_W         (CH_W)
        ) u_cell (
            .aclk               (aclk),
            .ctl                (ctl),
            .ch_idx             (ch_idx_reg),
            .count              (cnt_cur),
            .key                (key),
            .new_setting        (setting_reg),
            .prev_lt            (prev_lt),
            .prev_power         (prev_power),
            .prev_setting       (prev_setting),
            .prev_found         (prev_found),
            .prev_found_setting (prev_found_setting),
            .lt                 (lt_w[i]),
            .rd_power           (pw_w[i]),
            .rd_setting         (st_w[i]),
            .found              (fd_w[i]),
            .found_setting      (fs_w[i])
        );
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_setting_out = rpct_pkg::SET_PORT_W'(m_setting_reg);

endmodule
